### src/double_ended_queue_core_assert.svh
// Assertion macros shared by the deque core modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 3;
  localparam int ST_W      = 2;

  // Action codes carried on the input tuser.
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ_ALL   = 3'd4;

  // Result status codes carried on the output tuser.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic             start;   // item accepted this cycle
    logic             emit;    // load the output register this cycle
    logic [ACT_W-1:0] action;  // action in progress (input action while start)
  } deq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;       // no entries stored
    logic last_entry;  // read-out pointer is on the back entry
  } deq_stat_t;

endpackage

### src/deq_ram.sv
module deq_ram
  #(parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1)
  (input  logic             clk,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/deq_datapath.sv
module deq_datapath
  import deq_pkg::*;
  #(parameter int DEPTH = DEPTH_DEF)
  (input  logic              clk,
   input  logic              rst_n,
   input  deq_cmd_t          cmd,
   input  logic [WORD_W-1:0] in_value,
   output deq_stat_t         stat,
   output logic [WORD_W-1:0] out_value,
   output logic [ST_W-1:0]   out_status,
   output logic              out_last);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [WORD_W-1:0] value_r;
  logic [WORD_W-1:0] res_value_r, res_value_nxt;
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic              res_last_r, res_last_nxt;

  logic              empty, full, last_entry;
  logic [CW-1:0]     cnt_m1, idx_p1;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] rd_data;

  assign empty      = (count_r == '0);
  assign full       = (count_r == FULL_CNT);
  assign cnt_m1     = count_r - CW'(1);
  assign idx_p1     = idx_r + CW'(1);
  assign last_entry = (idx_p1 == count_r);

  assign stat.empty      = empty;
  assign stat.last_entry = last_entry;

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;

    if (cmd.start) begin
      // Fetch the entry that the action will need once it executes.
      rd_en   = 1'b1;
      ptr_nxt = head_r;
      idx_nxt = '0;
      if (cmd.action == ACT_POP_BACK) begin
        rd_addr = wrap_add(head_r, cnt_m1[AW-1:0]);
      end
    end

    if (cmd.emit) begin
      res_last_nxt = 1'b1;
      case (cmd.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          res_value_nxt  = value_r;
          res_status_nxt = full ? ST_FULL : ST_OK;
          if (!full) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            if (cmd.action == ACT_PUSH_FRONT) begin
              head_nxt = wrap_dec(head_r);
              wr_addr  = wrap_dec(head_r);
            end else begin
              wr_addr = wrap_add(head_r, count_r[AW-1:0]);
            end
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          res_value_nxt  = empty ? '0 : rd_data;
          res_status_nxt = empty ? ST_EMPTY : ST_OK;
          if (!empty) begin
            count_nxt = cnt_m1;
            if (cmd.action == ACT_POP_FRONT) begin
              head_nxt = wrap_inc(head_r);
            end
          end
        end
        ACT_READ_ALL: begin
          res_value_nxt  = empty ? '0 : rd_data;
          res_status_nxt = empty ? ST_EMPTY : ST_OK;
          res_last_nxt   = empty | last_entry;
          if (!empty && !last_entry) begin
            ptr_nxt = wrap_inc(ptr_r);
            idx_nxt = idx_p1;
            rd_en   = 1'b1;
            rd_addr = wrap_inc(ptr_r);
          end
        end
        default: begin
          res_last_nxt = res_last_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      ptr_r   <= '0;
      idx_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      idx_r   <= idx_nxt;
    end
    if (cmd.start) begin
      value_r <= in_value;
    end
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
  end

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_value  = res_value_r;
  assign out_status = res_status_r;
  assign out_last   = res_last_r;

`include "double_ended_queue_core_assert.svh"

  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT, "entry count above depth")
  `DEQ_ASSERT_NOW(a_head_bound, 1'b1, {1'b0, head_r} < DEPTH_X, "head index out of range")

endmodule

### src/deq_ctrl.sv
module deq_ctrl
  import deq_pkg::*;
  (input  logic             clk,
   input  logic             rst_n,
   input  logic             in_tvalid,
   input  logic [ACT_W-1:0] in_action,
   output logic             in_tready,
   output logic             out_tvalid,
   input  logic             out_tready,
   input  deq_stat_t        stat,
   output deq_cmd_t         cmd);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  logic [ACT_W-1:0] action_r, action_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             start, emit, done;

  assign in_tready = (state_r == S_IDLE);
  assign start     = in_tvalid & in_tready;
  assign emit      = (state_r == S_EMIT) & (~out_valid_r | out_tready);

  // A read-out keeps emitting until the back entry has gone out.
  assign done = emit & ((action_r != ACT_READ_ALL) | stat.empty | stat.last_entry);

  assign cmd.start  = start;
  assign cmd.emit   = emit;
  assign cmd.action = start ? in_action : action_r;

  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    out_valid_nxt = emit | (out_valid_r & ~out_tready);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          action_nxt = in_action;
          // Codes past the last action are dropped without a result.
          if (in_action <= ACT_READ_ALL) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      action_r    <= ACT_PUSH_FRONT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      action_r    <= action_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`include "double_ended_queue_core_assert.svh"

  `DEQ_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_tready, !cmd.emit, "pending result overwritten")
  `DEQ_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted result not presented")
  `DEQ_ASSERT_NEXT(a_start_exec, cmd.start && in_action <= ACT_READ_ALL, state_r == S_EMIT, "accepted action not executed")

endmodule

### src/double_ended_queue_core.sv
// Double-ended queue core: push/pop at either end, or read out all entries.
// A result is loaded into the output register in the emit state, once it is free.
// One item is handled at a time; a read-out emits one entry per cycle while the output
// side keeps up, set by the single registered read port of the entry store.
// Reset: synchronous, active-low rst_n clears head, count and control; the store itself
// is not cleared, as only written entries ever reach the output.
module double_ended_queue_core
  import deq_pkg::*;
  #(parameter int DEPTH = DEPTH_DEF)
  (input  logic              clk,
   input  logic              rst_n,
   // Input channel.
   input  logic              in_tvalid,
   output logic              in_tready,
   input  logic [WORD_W-1:0] in_tdata,   // [31:0] value
   input  logic [ACT_W-1:0]  in_tuser,   // [2:0] action
   // Result channel.
   output logic              out_tvalid,
   input  logic              out_tready,
   output logic [WORD_W-1:0] out_tdata,  // [31:0] value_res
   output logic [ST_W-1:0]   out_tuser,  // [1:0] status
   output logic              out_tlast);

  // The controller sequences one item at a time: it takes a transfer in
  // while idle, even when the previous result still sits in the output
  // register, and then executes the action once that register can be
  // loaded. A read-out walks the entries from front to back, issuing the
  // next store read in the same cycle that it emits the current entry, so
  // it sustains one result per cycle while the output side keeps up.
  // Unknown actions are accepted and dropped without a result.

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the pointers, the entry store and the output
  // register; pushes echo the pushed word, pops return the removed word.
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_tdata),
    .stat       (stat),
    .out_value  (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

### verif/deq_checker.sv
module deq_checker
  import deq_pkg::*;
  #(parameter int DEPTH = DEPTH_DEF)
  (input  logic              clk,
   input  logic              rst_n,
   input  logic              in_tvalid,
   input  logic              in_tready,
   input  logic [WORD_W-1:0] in_tdata,   // [31:0] value
   input  logic [ACT_W-1:0]  in_tuser,   // [2:0] action
   input  logic              out_tvalid,
   input  logic              out_tready,
   input  logic [WORD_W-1:0] out_tdata,  // [31:0] value_res
   input  logic [ST_W-1:0]   out_tuser,  // [1:0] status
   input  logic              out_tlast,
   output int                mismatch_count,
   output int                results_owed);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [ST_W-1:0]   status;
    logic              last;
  } deq_result_t;

  // Expected results in order, indexed by a running write and read count.
  deq_result_t       owed_mem[int];
  int                owe_wr;
  int                owe_rd;
  logic [WORD_W-1:0] ring[DEPTH];
  int unsigned       front_at;
  int unsigned       occupancy;

  function automatic int unsigned ring_pos(input int unsigned offset);
    return (front_at + offset) % DEPTH;
  endfunction

  function automatic void owe(input logic [WORD_W-1:0] word, input logic [ST_W-1:0] status,
                              input logic last);
    deq_result_t r;
    r.word   = word;
    r.status = status;
    r.last   = last;
    owed_mem[owe_wr] = r;
    owe_wr++;
  endfunction

  // Updates the shadow deque for one accepted item and queues what it must produce.
  task automatic apply_action(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] popped;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (occupancy >= DEPTH) begin
          owe(word, ST_FULL, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            front_at = ring_pos(DEPTH - 1);
            ring[front_at] = word;
          end else begin
            ring[ring_pos(occupancy)] = word;
          end
          occupancy++;
          owe(word, ST_OK, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (occupancy == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            popped   = ring[front_at];
            front_at = ring_pos(1);
          end else begin
            popped = ring[ring_pos(occupancy - 1)];
          end
          occupancy--;
          owe(popped, ST_OK, 1'b1);
        end
      end
      ACT_READ_ALL: begin
        if (occupancy == 0) begin
          owe('0, ST_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < occupancy; i++)
            owe(ring[ring_pos(i)], ST_OK, i + 1 == occupancy);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    deq_result_t want;
    if (owe_rd == owe_wr) begin
      $display("%0t: result with nothing expected: value_res=%h status=%0d last=%0b",
               $time, out_tdata, out_tuser, out_tlast);
      mismatch_count++;
    end else begin
      want = owed_mem[owe_rd];
      owed_mem.delete(owe_rd);
      owe_rd++;
      if (out_tdata !== want.word) begin
        $display("%0t: value_res expected %h, got %h", $time, want.word, out_tdata);
        mismatch_count++;
      end
      if (out_tuser !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser);
        mismatch_count++;
      end
      if (out_tlast !== want.last) begin
        $display("%0t: last expected %0b, got %0b", $time, want.last, out_tlast);
        mismatch_count++;
      end
    end
  endtask

  // A result always trails its own input transfer, so results are checked before the
  // input transfer of the same edge is folded in.
  always @(posedge clk) begin
    if (!rst_n) begin
      front_at       = 0;
      occupancy      = 0;
      owe_wr         = 0;
      owe_rd         = 0;
      mismatch_count = 0;
      owed_mem.delete();
    end else begin
      if (out_tvalid && out_tready)
        check_result();
      if (in_tvalid && in_tready)
        apply_action(in_tuser, in_tdata);
    end
    results_owed = owe_wr - owe_rd;
  end

endmodule

### verif/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // Items per random phase; three phases give roughly the intended random volume.
  localparam int PHASE_ITEMS = 50;
  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata   = '0;     // [31:0] value
  logic [ACT_W-1:0]  in_tuser   = '0;     // [2:0] action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [WORD_W-1:0] out_tdata;           // [31:0] value_res
  logic [ST_W-1:0]   out_tuser;           // [1:0] status
  logic              out_tlast;

  int mismatch_count;
  int results_owed;

  // Idle rates in percent for the sending and the receiving side.
  int src_idle_pct  = 33;
  int sink_idle_pct = 51;

  // Occupancy as seen by the stimulus, used only to steer sequences toward full and empty.
  int stored     = 0;
  // Count of accepted items that the block acts on; ignored actions are not counted.
  int sent_items = 0;
  int quiet_cycles = 0;

  double_ended_queue_core #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  deq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides at every falling edge whether it will take a result at the
  // next rising edge, so stalls can land on any beat of a multi-result read-out.
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= sink_idle_pct);
  end

  // The watchdog restarts on any transfer. A correct run never goes quiet for long:
  // the longest gaps are random idle streaks and the short settling waits between parts.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL double_ended_queue_core");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return {1'b1, {(WORD_W-1){1'b0}}};
      1:       return {1'b0, {(WORD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Presents one item from a falling edge and returns at the falling edge after its
  // transfer. Valid is left high so that a following item goes out back to back;
  // it drops only when the sender chooses to idle.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: if (stored < DEPTH) stored++;
      ACT_POP_FRONT, ACT_POP_BACK:   if (stored > 0) stored--;
      default: ;
    endcase
    if (act <= ACT_READ_ALL)
      sent_items++;
  endtask

  task automatic random_push();
    send_item($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, random_word());
  endtask

  task automatic random_pop();
    send_item($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, random_word());
  endtask

  // Pushes from either end, with an occasional read-out, until the deque is full, then pushes into the full deque.
  // A read-out at full length follows half of the time.
  task automatic fill_run();
    while (stored < DEPTH) begin
      if ($urandom_range(7) == 0)
        send_item(ACT_READ_ALL, random_word());
      else
        random_push();
    end
    repeat ($urandom_range(1, 2)) random_push();
    if ($urandom_range(1))
      send_item(ACT_READ_ALL, random_word());
  endtask

  // Pops from either end, with an occasional read-out, until empty, then pops the empty deque.
  task automatic drain_run();
    while (stored > 0) begin
      if ($urandom_range(7) == 0)
        send_item(ACT_READ_ALL, random_word());
      else
        random_pop();
    end
    repeat ($urandom_range(1, 2)) random_pop();
  endtask

  // A short stretch of mixed traffic, with an occasional ignored action as noise.
  task automatic mixed_run();
    repeat (8) begin
      case ($urandom_range(9))
        0, 1, 2, 3: random_push();
        4, 5, 6:    random_pop();
        7:          send_item(ACT_READ_ALL, random_word());
        8:          send_item(ACT_W'($urandom_range(5, 7)), random_word());
        default:    send_item(ACT_W'($urandom_range(7)), random_word());
      endcase
    end
  endtask

  // Holds the sender off until every expected result has come, then gives an ignored
  // item or a read-out still in flight time to finish.
  task automatic settle();
    in_tvalid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct);
    int goal;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    goal = sent_items + PHASE_ITEMS;
    fill_run();
    while (sent_items < goal) begin
      case ($urandom_range(2))
        0:       fill_run();
        1:       drain_run();
        default: mixed_run();
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: everything on an empty deque, the ignored actions, word extremes
    // pushed at both ends (the first front push wraps the head below slot zero), a
    // read-out, and pops from both ends down to empty and one beyond.
    send_item(ACT_POP_FRONT, '1);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_READ_ALL, '1);
    send_item(3'd5, 32'h5555_5555);
    send_item(3'd6, 32'hAAAA_AAAA);
    send_item(3'd7, '1);
    send_item(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
    send_item(ACT_PUSH_BACK, 32'h8000_0000);
    send_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(ACT_PUSH_BACK, 32'h0000_0000);
    send_item(ACT_READ_ALL, '0);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_POP_FRONT, '1);
    send_item(ACT_POP_FRONT, '0);
    send_item(ACT_POP_BACK, '1);
    send_item(ACT_POP_BACK, '0);
    send_item(ACT_READ_ALL, '0);
    settle();

    // Random part in three idle settings; each phase opens by filling to full.
    random_phase(33, 51);
    settle();
    random_phase(51, 33);
    settle();
    random_phase(0, 0);
    settle();

    if (mismatch_count == 0)
      $display("PASS double_ended_queue_core");
    else
      $display("FAIL double_ended_queue_core");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/deq_pkg.sv
src/deq_ram.sv
src/deq_datapath.sv
src/deq_ctrl.sv
src/double_ended_queue_core.sv
verif/deq_checker.sv
verif/tb_top.sv
